// ===== sv/tvsf_pkg.sv =====
// tvsf_pkg: shared types and constants for the three value sum finder
// no dependencies; used by tvsf_engine, three_value_sum_finder, tvsf_checker and testbench
package tvsf_pkg;

    // store geometry
    localparam int MAX_ITEMS = 1024;
    localparam int AW        = $clog2(MAX_ITEMS);
    localparam int CW        = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 32;
    localparam int POS_W     = 11;

    // input beat
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] second_pos;
        logic [POS_W-1:0] third_pos;
    } t_result;

    // one store entry: value and arrival position
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [AW-1:0]    pos;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // memory access request from the engine
    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        t_entry        wdata;
        logic          re;
        logic [AW-1:0] raddr;
    } t_mem_req;

endpackage

// ===== sv/tvsf_ram.sv =====
// tvsf_ram: generic single-write, single-read synchronous ram
// read data registered, held while no read is issued; no dependencies
module tvsf_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 42
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== sv/tvsf_engine.sv =====
// tvsf_engine: load, insertion sort and binary search sequencer over the store
// depends on tvsf_pkg; drives the store through a t_mem_req bundle
module tvsf_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tvsf_pkg::t_in_item i_item,
    output logic               o_strobe,
    output tvsf_pkg::t_result  o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    output tvsf_pkg::t_mem_req o_req,
    input  tvsf_pkg::t_entry   i_rdata
);

    localparam int CW = tvsf_pkg::CW;
    localparam int AW = tvsf_pkg::AW;
    localparam int PW = tvsf_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SORT_NEXT, S_SORT_KEY, S_SORT_PREV, S_SORT_CMP,
        S_I_RD, S_I_DAT, S_J_RD, S_J_DAT, S_PAIR, S_BS, S_BS_DAT,
        S_DN, S_UP_RD, S_UP
    } t_state;

    t_state                r_state;
    logic [31:0]           r_target;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_n;
    logic [CW-1:0]         r_a;
    logic [CW-1:0]         r_b;
    logic [CW-1:0]         r_i;
    logic [CW-1:0]         r_j;
    logic [CW-1:0]         r_lo;
    logic [CW-1:0]         r_hi1;
    logic [CW-1:0]         r_k;
    logic [CW-1:0]         r_mid;
    tvsf_pkg::t_entry      r_key;
    logic [AW-1:0]         r_pi;
    logic [AW-1:0]         r_pj;
    logic [31:0]           r_vi;
    logic [32:0]           r_pair;
    logic [31:0]           r_want;
    logic                  r_strobe;
    tvsf_pkg::t_result     r_result;

    logic          key_gt;
    logic          pos_ok;
    logic          val_eq;
    logic          room;
    logic [CW-1:0] mid;
    logic [CW-1:0] n_count;

    // compare helpers
    assign key_gt = (i_rdata.value > r_key.value) ||
                    ((i_rdata.value == r_key.value) && (i_rdata.pos > r_key.pos));
    assign pos_ok = (i_rdata.pos != r_pi) && (i_rdata.pos != r_pj);
    assign val_eq = (i_rdata.value == r_want);
    assign room   = (r_count < CW'(tvsf_pkg::MAX_ITEMS));
    assign mid    = r_lo + ((r_hi1 - CW'(1) - r_lo) >> 1);
    assign n_count = room ? (r_count + CW'(1)) : r_count;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;

    // store requests
    always_comb begin
        o_req       = '0;
        o_req.wdata = r_key;
        case (r_state)
            S_IDLE: begin
                if (start && room) begin
                    o_req.we          = 1'b1;
                    o_req.waddr       = r_count[AW-1:0];
                    o_req.wdata.value = i_item.value;
                    o_req.wdata.pos   = r_count[AW-1:0];
                end
            end
            S_SORT_NEXT: begin
                o_req.re    = (r_a < r_n);
                o_req.raddr = r_a[AW-1:0];
            end
            S_SORT_PREV: begin
                if (r_b == '0) begin
                    o_req.we    = 1'b1;
                    o_req.waddr = '0;
                end else begin
                    o_req.re    = 1'b1;
                    o_req.raddr = r_b[AW-1:0] - AW'(1);
                end
            end
            S_SORT_CMP: begin
                o_req.we    = 1'b1;
                o_req.waddr = r_b[AW-1:0];
                o_req.wdata = key_gt ? i_rdata : r_key;
            end
            S_I_RD: begin
                o_req.re    = (r_i < r_n);
                o_req.raddr = r_i[AW-1:0];
            end
            S_J_RD: begin
                o_req.re    = (r_j < r_n);
                o_req.raddr = r_j[AW-1:0];
            end
            S_BS: begin
                o_req.re    = (r_lo < r_hi1);
                o_req.raddr = mid[AW-1:0];
            end
            S_DN: begin
                o_req.re    = val_eq && !pos_ok && (r_k != '0);
                o_req.raddr = r_k[AW-1:0] - AW'(1);
            end
            S_UP_RD: begin
                o_req.re    = (r_k < r_n);
                o_req.raddr = r_k[AW-1:0];
            end
            default: begin
                o_req.re = 1'b0;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_target <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_target <= i_cfg_data;
                    end
                    if (start) begin
                        if (i_item.last) begin
                            r_n     <= n_count;
                            r_count <= '0;
                            r_a     <= CW'(1);
                            r_state <= S_SORT_NEXT;
                        end else begin
                            r_count <= n_count;
                        end
                    end
                end
                S_SORT_NEXT: begin
                    if (r_a < r_n) begin
                        r_state <= S_SORT_KEY;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_I_RD;
                    end
                end
                S_SORT_KEY: begin
                    r_key   <= i_rdata;
                    r_b     <= r_a;
                    r_state <= S_SORT_PREV;
                end
                S_SORT_PREV: begin
                    if (r_b == '0) begin
                        r_a     <= r_a + CW'(1);
                        r_state <= S_SORT_NEXT;
                    end else begin
                        r_state <= S_SORT_CMP;
                    end
                end
                S_SORT_CMP: begin
                    if (key_gt) begin
                        r_b     <= r_b - CW'(1);
                        r_state <= S_SORT_PREV;
                    end else begin
                        r_a     <= r_a + CW'(1);
                        r_state <= S_SORT_NEXT;
                    end
                end
                S_I_RD: begin
                    if (r_i < r_n) begin
                        r_j     <= r_i + CW'(1);
                        r_state <= S_I_DAT;
                    end else begin
                        r_result <= '0;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_I_DAT: begin
                    r_vi    <= i_rdata.value;
                    r_pi    <= i_rdata.pos;
                    r_state <= S_J_RD;
                end
                S_J_RD: begin
                    if (r_j < r_n) begin
                        r_state <= S_J_DAT;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_I_RD;
                    end
                end
                S_J_DAT: begin
                    r_pj    <= i_rdata.pos;
                    r_pair  <= {1'b0, r_vi} + {1'b0, i_rdata.value};
                    r_state <= S_PAIR;
                end
                S_PAIR: begin
                    if (r_pair > {1'b0, r_target}) begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_J_RD;
                    end else begin
                        r_want  <= r_target - r_pair[31:0];
                        r_lo    <= '0;
                        r_hi1   <= r_n;
                        r_state <= S_BS;
                    end
                end
                S_BS: begin
                    if (r_lo < r_hi1) begin
                        r_mid   <= mid;
                        r_k     <= mid;
                        r_state <= S_BS_DAT;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_J_RD;
                    end
                end
                S_BS_DAT: begin
                    if (val_eq) begin
                        r_state <= S_DN;
                    end else if (i_rdata.value < r_want) begin
                        r_lo    <= r_mid + CW'(1);
                        r_state <= S_BS;
                    end else begin
                        r_hi1   <= r_mid;
                        r_state <= S_BS;
                    end
                end
                // downward scan from the probe
                S_DN: begin
                    if (val_eq && pos_ok) begin
                        r_result.found      <= 1'b1;
                        r_result.first_pos  <= PW'({1'b0, r_pi}) + PW'(1);
                        r_result.second_pos <= PW'({1'b0, r_pj}) + PW'(1);
                        r_result.third_pos  <= PW'({1'b0, i_rdata.pos}) + PW'(1);
                        r_strobe            <= 1'b1;
                        r_state             <= S_IDLE;
                    end else if (val_eq && (r_k != '0)) begin
                        r_k <= r_k - CW'(1);
                    end else begin
                        r_k     <= r_mid + CW'(1);
                        r_state <= S_UP_RD;
                    end
                end
                // upward scan above the probe
                S_UP_RD: begin
                    if (r_k < r_n) begin
                        r_state <= S_UP;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_J_RD;
                    end
                end
                S_UP: begin
                    if (val_eq && pos_ok) begin
                        r_result.found      <= 1'b1;
                        r_result.first_pos  <= PW'({1'b0, r_pi}) + PW'(1);
                        r_result.second_pos <= PW'({1'b0, r_pj}) + PW'(1);
                        r_result.third_pos  <= PW'({1'b0, i_rdata.pos}) + PW'(1);
                        r_strobe            <= 1'b1;
                        r_state             <= S_IDLE;
                    end else if (val_eq) begin
                        r_k     <= r_k + CW'(1);
                        r_state <= S_UP_RD;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_J_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/three_value_sum_finder.sv =====
// three_value_sum_finder: top level, store ram plus search sequencer
// depends on tvsf_pkg, tvsf_ram and tvsf_engine
//
// usage:
//   input beats (value, last) are taken when start is high and busy is low.
//   each value is stored with its arrival position; beats past the store
//   depth are dropped, but their last mark still starts the search.
//   a beat without last does not raise busy; the next can follow at once.
//   a beat with last raises busy while the store is insertion sorted in
//   place and then every sorted pair i<j is binary searched for the
//   third value, plus a scan over equal values; pairs whose sum is
//   above the target skip the search.
//   the store has a single ram read port, one read per step.
//   the result beat is shown for one cycle with o_strobe high; the
//   receiver cannot stall, so it must take it then. busy falls together
//   with the strobe.
//   the target sum is written over the cfg channel, ready while not busy.
//   reset clears the target, the load count and the sequencer; the store
//   itself is not cleared and needs none.
module three_value_sum_finder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tvsf_pkg::t_in_item i_item,
    output logic               o_strobe,
    output tvsf_pkg::t_result  o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);

    tvsf_pkg::t_mem_req req;
    tvsf_pkg::t_entry   rdata;

    // value and position store
    tvsf_ram #(
        .DEPTH (tvsf_pkg::MAX_ITEMS),
        .WIDTH (tvsf_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (req.we),
        .i_waddr (req.waddr),
        .i_wdata (req.wdata),
        .i_re    (req.re),
        .i_raddr (req.raddr),
        .o_rdata (rdata)
    );

    // sequencer
    tvsf_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_req       (req),
        .i_rdata     (rdata)
    );

endmodule

// ===== sim/tvsf_checker.sv =====
// tvsf_checker: watches the item, result and cfg channels of the sum finder,
// predicts every result beat and compares it; depends on tvsf_pkg
`timescale 1ns / 100ps

module tvsf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  tvsf_pkg::t_in_item i_item,
    input  logic               i_strobe,
    input  tvsf_pkg::t_result  i_result,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count
);

    logic [tvsf_pkg::VAL_W-1:0] sorted_val [tvsf_pkg::MAX_ITEMS];
    logic [tvsf_pkg::AW-1:0]    sorted_pos [tvsf_pkg::MAX_ITEMS];
    int                         held_count;
    logic [31:0]                sum_goal;
    tvsf_pkg::t_result          triple_q[$];
    int                         mismatch_count;

    // leftovers count as failures as well
    assign o_fail_count = mismatch_count + triple_q.size();

    // binary probe, then scan down and up over equal values
    function automatic int probe_third(logic [31:0] want, logic [tvsf_pkg::AW-1:0] pa,
                                       logic [tvsf_pkg::AW-1:0] pb, int n);
        int lo;
        int hi;
        int mid;
        int k;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (sorted_val[mid] == want) begin
                for (k = mid; k >= 0 && sorted_val[k] == want; k--)
                    if (sorted_pos[k] != pa && sorted_pos[k] != pb) return k;
                for (k = mid + 1; k < n && sorted_val[k] == want; k++)
                    if (sorted_pos[k] != pa && sorted_pos[k] != pb) return k;
                return -1;
            end else if (sorted_val[mid] < want) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return -1;
    endfunction

    // sort by value then position, walk pairs, search the remainder
    function automatic tvsf_pkg::t_result search_triple(int n);
        tvsf_pkg::t_result          res;
        logic [tvsf_pkg::VAL_W-1:0] v;
        logic [tvsf_pkg::AW-1:0]    p;
        logic [32:0]                pair;
        int                         b;
        int                         hit;
        res = '0;
        for (int a = 1; a < n; a++) begin
            v = sorted_val[a];
            p = sorted_pos[a];
            b = a;
            while (b > 0 && (sorted_val[b-1] > v ||
                   (sorted_val[b-1] == v && sorted_pos[b-1] > p))) begin
                sorted_val[b] = sorted_val[b-1];
                sorted_pos[b] = sorted_pos[b-1];
                b--;
            end
            sorted_val[b] = v;
            sorted_pos[b] = p;
        end
        for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j < n; j++) begin
                pair = {1'b0, sorted_val[i]} + {1'b0, sorted_val[j]};
                if (pair > {1'b0, sum_goal}) continue;
                hit = probe_third(sum_goal - pair[31:0], sorted_pos[i], sorted_pos[j], n);
                if (hit >= 0) begin
                    res.found      = 1'b1;
                    res.first_pos  = tvsf_pkg::POS_W'(sorted_pos[i]) + 1'b1;
                    res.second_pos = tvsf_pkg::POS_W'(sorted_pos[j]) + 1'b1;
                    res.third_pos  = tvsf_pkg::POS_W'(sorted_pos[hit]) + 1'b1;
                    return res;
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        tvsf_pkg::t_result want;
        if (!i_rst_n) begin
            held_count     <= 0;
            sum_goal       <= '0;
            mismatch_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) sum_goal <= i_cfg_data;
            // input beat: store, and on last predict
            if (i_start && !i_busy) begin
                if (held_count < tvsf_pkg::MAX_ITEMS) begin
                    sorted_val[held_count] = i_item.value;
                    sorted_pos[held_count] = tvsf_pkg::AW'(held_count);
                end
                if (i_item.last) begin
                    triple_q.insert(triple_q.size(),
                                    search_triple(held_count < tvsf_pkg::MAX_ITEMS ?
                                                  held_count + 1 : tvsf_pkg::MAX_ITEMS));
                    held_count <= 0;
                end else if (held_count < tvsf_pkg::MAX_ITEMS) begin
                    held_count <= held_count + 1;
                end
            end
            // result beat
            if (i_strobe) begin
                if (triple_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result beat %p", i_result);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = triple_q.pop_front();
                    if (want.found !== i_result.found
                        || want.first_pos !== i_result.first_pos
                        || want.second_pos !== i_result.second_pos
                        || want.third_pos !== i_result.third_pos) begin
                        if (mismatch_count < 10)
                            $display("result mismatch: expected %p got %p", want, i_result);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
// testbench: stimulus and verdict for three_value_sum_finder
// depends on tvsf_pkg, the block's rtl and tvsf_checker
`timescale 1ns / 100ps

module testbench;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    tvsf_pkg::t_in_item i_item;
    logic               o_strobe;
    tvsf_pkg::t_result  o_result;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [31:0]        i_cfg_data;
    int                 fail_count;
    int                 idle_cycles;
    int                 burst_left;
    int                 gap_max;
    int                 items_sent;
    logic [31:0]        set_vals [$];

    three_value_sum_finder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    tvsf_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_item(i_item), .i_strobe(o_strobe), .i_result(o_result),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data), .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one input beat, with burst gaps in front
    task automatic send_beat(logic [31:0] v, logic lst);
        int g;
        if (burst_left == 0) begin
            g = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
            if (g > 0) begin
                start <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            burst_left = $urandom_range(16, 1);
        end
        burst_left--;
        start       <= 1'b1;
        i_item.value <= v;
        i_item.last  <= lst;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // send the queued set, then wait for its result beat
    task automatic send_set();
        foreach (set_vals[k]) send_beat(set_vals[k], k == set_vals.size() - 1);
        start <= 1'b0;
        do @(posedge i_clk); while (!o_strobe);
    endtask

    task automatic write_target(logic [31:0] t);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // random set: value spread picked per set, sometimes a target built from set values
    task automatic random_set();
        int n;
        int spread;
        int a;
        int b;
        int c;
        n = ($urandom_range(9, 0) == 0) ? $urandom_range(2, 1)
          : ($urandom_range(15, 0) == 0) ? $urandom_range(40, 21) : $urandom_range(20, 3);
        spread = $urandom_range(2, 0);
        set_vals.delete();
        repeat (n) begin
            case (spread)
                0: set_vals.insert(set_vals.size(), $urandom_range(15, 0));
                1: set_vals.insert(set_vals.size(), $urandom_range(1000, 0));
                default: set_vals.insert(set_vals.size(), $urandom);
            endcase
        end
        case ($urandom_range(5, 0))
            0, 1, 2: if (n >= 3) begin
                a = $urandom_range(n - 1, 0);
                b = $urandom_range(n - 1, 0);
                c = $urandom_range(n - 1, 0);
                write_target(set_vals[a] + set_vals[b] + set_vals[c]);
            end
            3: write_target($urandom_range(40, 0));
            4: write_target($urandom);
            default: ;
        endcase
        send_set();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        idle_cycles = 0;
        burst_left  = 0;
        gap_max     = 0;
        items_sent  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zeros with target zero, one and two values
        set_vals = '{0, 0, 0};
        send_set();
        set_vals = '{7};
        send_set();
        set_vals = '{3, 4};
        send_set();
        // all-ones target, pair sums past the target
        write_target(32'hFFFF_FFFF);
        set_vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_set();
        set_vals = '{32'hFFFF_FFFD, 1, 0, 1, 32'h8000_0000};
        send_set();
        // duplicates where the probe hits a pair member
        write_target(15);
        set_vals = '{5, 5, 5, 5};
        send_set();
        set_vals = '{10, 2, 3, 9, 1};
        send_set();

        // random sets, gap pattern changes per phase
        while (items_sent < 260) begin
            gap_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            random_set();
        end

        // overflow: more than the store holds, equal values find quickly
        gap_max = 2;
        write_target(3 * 32'd77);
        set_vals.delete();
        repeat (tvsf_pkg::MAX_ITEMS + 6) set_vals.insert(set_vals.size(), 32'd77);
        send_set();
        // load count starts again from zero afterwards
        gap_max = 4;
        random_set();

        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
